### rtl/core/hgcp_pkg.sv
package hgcp_pkg;

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_LF     = 8'h0a;
   localparam logic [7:0] CHAR_CR     = 8'h0d;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_EQUALS = 8'h3d;

   localparam logic [7:0] CHAR_G = 8'h47;
   localparam logic [7:0] CHAR_E = 8'h45;
   localparam logic [7:0] CHAR_T = 8'h54;

   localparam int WIN_LEN    = 9;
   localparam int URI_LEN    = 9;
   localparam int KW_FW_LEN  = 6;
   localparam int KW_BW_LEN  = 6;
   localparam int KW_RT_LEN  = 9;
   localparam int KW_LF_LEN  = 8;

   localparam logic [8*URI_LEN-1:0]   KW_URI = "/?command";
   localparam logic [8*KW_FW_LEN-1:0] KW_FW  = "FW_CMD";
   localparam logic [8*KW_BW_LEN-1:0] KW_BW  = "BW_CMD";
   localparam logic [8*KW_RT_LEN-1:0] KW_RT  = 72'h52_49_47_48_54_5f_43_4d_44;
   localparam logic [8*KW_LF_LEN-1:0] KW_LF  = 64'h4c_45_46_54_5f_43_4d_44;

   localparam logic [2:0] CMD_NONE     = 3'd0;
   localparam logic [2:0] CMD_FORWARD  = 3'd1;
   localparam logic [2:0] CMD_BACKWARD = 3'd2;
   localparam logic [2:0] CMD_RIGHT    = 3'd3;
   localparam logic [2:0] CMD_LEFT     = 3'd4;

   localparam logic [2:0] GET_MATCHED  = 3'd3;
   localparam logic [2:0] GET_MISMATCH = 3'd4;

   typedef struct packed {
      logic       header_end;
      logic       request_matched;
      logic [2:0] command;
   } result_type;

endpackage

### rtl/core/hgcp_line_parser.sv
module hgcp_line_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic [7:0]             data_byte,
   output logic                   emit,
   output hgcp_pkg::result_type   result
);

   typedef struct packed {
      logic [1:0]                         line_length;
      logic                               last_was_cr;
      logic [1:0]                         token_number;
      logic                               inside_token;
      logic [2:0]                         first_token_progress;
      logic [8*hgcp_pkg::WIN_LEN-1:0]     char_window;
      logic                               uri_found;
      logic                               equals_seen;
      logic [3:0]                         chars_after_equals;
      logic [3:0]                         keyword_flags;
      logic [2:0]                         current_command;
   } line_state_type;

   line_state_type                   state_ff;
   line_state_type                   state_in;
   logic [1:0]                       token_next;
   logic [8*hgcp_pkg::WIN_LEN-1:0]   window_base;
   logic [8*hgcp_pkg::WIN_LEN-1:0]   window_next;
   logic [3:0]                       count_next;
   logic                             matched;
   logic [2:0]                       command_next;

   always_comb begin
      token_next = state_ff.token_number;
      if (!state_ff.inside_token && state_ff.token_number != 2'd3) begin
         token_next = state_ff.token_number + 2'd1;
      end
      window_base = (!state_ff.inside_token && token_next == 2'd2) ? '0 : state_ff.char_window;
      window_next = {window_base[8*hgcp_pkg::WIN_LEN-9:0], data_byte};
      count_next  = (state_ff.chars_after_equals == 4'd15) ? 4'd15
                                                          : state_ff.chars_after_equals + 4'd1;
      matched = state_ff.line_length != 2'd1 && state_ff.token_number >= 2'd2
                && state_ff.first_token_progress == hgcp_pkg::GET_MATCHED
                && state_ff.uri_found && state_ff.equals_seen;
      command_next = state_ff.current_command;
      if (matched) begin
         priority if (state_ff.keyword_flags[3]) begin
            command_next = hgcp_pkg::CMD_LEFT;
         end else if (state_ff.keyword_flags[2]) begin
            command_next = hgcp_pkg::CMD_RIGHT;
         end else if (state_ff.keyword_flags[1]) begin
            command_next = hgcp_pkg::CMD_BACKWARD;
         end else if (state_ff.keyword_flags[0]) begin
            command_next = hgcp_pkg::CMD_FORWARD;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      emit     = 1'b0;
      result.header_end      = state_ff.line_length == 2'd1;
      result.request_matched = matched;
      result.command         = command_next;
      if (enable && data_byte != hgcp_pkg::CHAR_NUL) begin
         if (data_byte == hgcp_pkg::CHAR_LF) begin
            if (state_ff.last_was_cr) begin
               emit     = 1'b1;
               state_in = '0;
               state_in.current_command = command_next;
            end
         end else begin
            if (state_ff.line_length != 2'd2) begin
               state_in.line_length = state_ff.line_length + 2'd1;
            end
            state_in.last_was_cr = data_byte == hgcp_pkg::CHAR_CR;
            if (data_byte == hgcp_pkg::CHAR_SPACE) begin
               state_in.inside_token = 1'b0;
            end else begin
               state_in.inside_token = 1'b1;
               state_in.token_number = token_next;
               if (token_next == 2'd1) begin
                  priority if (state_ff.first_token_progress == 3'd0
                               && data_byte == hgcp_pkg::CHAR_G) begin
                     state_in.first_token_progress = 3'd1;
                  end else if (state_ff.first_token_progress == 3'd1
                               && data_byte == hgcp_pkg::CHAR_E) begin
                     state_in.first_token_progress = 3'd2;
                  end else if (state_ff.first_token_progress == 3'd2
                               && data_byte == hgcp_pkg::CHAR_T) begin
                     state_in.first_token_progress = hgcp_pkg::GET_MATCHED;
                  end else begin
                     state_in.first_token_progress = hgcp_pkg::GET_MISMATCH;
                  end
               end else if (token_next == 2'd2) begin
                  state_in.char_window = window_next;
                  if (window_next[8*hgcp_pkg::URI_LEN-1:0] == hgcp_pkg::KW_URI) begin
                     state_in.uri_found = 1'b1;
                  end
                  if (state_ff.equals_seen) begin
                     state_in.chars_after_equals = count_next;
                     if (count_next >= 4'(hgcp_pkg::KW_FW_LEN)
                         && window_next[8*hgcp_pkg::KW_FW_LEN-1:0] == hgcp_pkg::KW_FW) begin
                        state_in.keyword_flags[0] = 1'b1;
                     end
                     if (count_next >= 4'(hgcp_pkg::KW_BW_LEN)
                         && window_next[8*hgcp_pkg::KW_BW_LEN-1:0] == hgcp_pkg::KW_BW) begin
                        state_in.keyword_flags[1] = 1'b1;
                     end
                     if (count_next >= 4'(hgcp_pkg::KW_RT_LEN)
                         && window_next[8*hgcp_pkg::KW_RT_LEN-1:0] == hgcp_pkg::KW_RT) begin
                        state_in.keyword_flags[2] = 1'b1;
                     end
                     if (count_next >= 4'(hgcp_pkg::KW_LF_LEN)
                         && window_next[8*hgcp_pkg::KW_LF_LEN-1:0] == hgcp_pkg::KW_LF) begin
                        state_in.keyword_flags[3] = 1'b1;
                     end
                  end else if (data_byte == hgcp_pkg::CHAR_EQUALS) begin
                     state_in.equals_seen = 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      emit |-> !(result.header_end && result.request_matched))
      else $error("header end and request match in one item");

   assert property (@(posedge clock) disable iff (reset)
      emit |-> data_byte == hgcp_pkg::CHAR_LF && state_ff.last_was_cr)
      else $error("result without CR LF");

   assert property (@(posedge clock) disable iff (reset)
      state_ff.current_command <= hgcp_pkg::CMD_LEFT)
      else $error("stored command out of range");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff.token_number < 2'd2) |-> state_ff.char_window == '0 || state_ff.token_number == 2'd0
      || !state_ff.uri_found)
      else $error("second token state set before second token");

endmodule

### rtl/core/http_get_command_line_parser.sv
// Takes one byte of HTTP request header per cycle on req_ while the result register does
// not stall, and returns one item on rsp_ for every line closed by CR LF: rsp_tlast marks
// the lone CR line that ends the header, and rsp_tdata carries the GET match flag and the
// stored command. Zero bytes and LF bytes not preceded by CR are consumed without a result.
// The line state update lies between the input register and the result register; a result
// is registered when its LF leaves the input register and the result register is free.
// req_tready follows rsp_tready combinationally when both registers are full.
module http_get_command_line_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] request_matched, [3:1] command, [7:4] zero
   output logic       rsp_tlast    // header_end
);

   logic                  in_valid_ff;
   logic [7:0]            in_byte_ff;
   logic                  out_valid_ff;
   hgcp_pkg::result_type  out_result_ff;
   logic                  advance;
   logic                  emit;
   hgcp_pkg::result_type  result;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   hgcp_line_parser parser (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .data_byte (in_byte_ff),
      .emit      (emit),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance && emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
      if (advance && emit) begin
         out_result_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_result_ff.header_end;
   assign rsp_tdata  = {4'd0, out_result_ff.command, out_result_ff.request_matched};

endmodule
